// ===== hw/rtl/hpr_pkg.sv =====
// shared types and constants for the heater power ramp block
// no dependencies
`timescale 1ns / 1ps

package hpr_pkg;

    localparam int RAW_W      = 12;
    localparam int TEMP_W     = 12;
    localparam int HEAT_W     = 7;
    localparam int IVAL_W     = 16;
    localparam int PHASE_W    = 10;
    localparam int NUM_W      = 20;
    localparam int DEN_W      = 12;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [12:0]         TEMP_OFFSET  = 13'd150;
    localparam logic [PHASE_W-1:0]  PWM_PERIOD   = 10'd1000;
    localparam logic [HEAT_W-1:0]   POWER_MAX    = 7'd100;
    localparam logic [IVAL_W-1:0]   SAMPLE_RESET = 16'd5000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_TEMP      = 3'd0,
        REG_START_HEAT      = 3'd1,
        REG_LIMIT_TEMP      = 3'd2,
        REG_MAX_HEAT        = 3'd3,
        REG_SAMPLE_INTERVAL = 3'd4
    } reg_index_t;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_TEMP  = 8'b0000_0010,
        ST_CMP   = 8'b0000_0100,
        ST_MUL   = 8'b0000_1000,
        ST_DIVGO = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_FIN   = 8'b0100_0000,
        ST_PWM   = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] start_temp;
        logic [HEAT_W-1:0]        start_heat;
        logic signed [TEMP_W-1:0] limit_temp;
        logic [HEAT_W-1:0]        max_heat;
        logic [IVAL_W-1:0]        sample_interval;
    } cfg_t;

endpackage

// ===== hw/rtl/hpr_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on hpr_pkg
`timescale 1ns / 1ps

module hpr_div
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [hpr_pkg::NUM_W-1:0] dividend,
    input  logic [hpr_pkg::DEN_W-1:0] divisor,
    output logic                     done,
    output logic [hpr_pkg::NUM_W-1:0] quotient
);

    logic                        busy_reg;
    logic                        done_reg;
    logic [hpr_pkg::CNT_W-1:0]   cnt_reg;
    logic [hpr_pkg::DEN_W-1:0]   rem_reg;
    logic [hpr_pkg::NUM_W-1:0]   dvd_reg;
    logic [hpr_pkg::DEN_W-1:0]   den_reg;

    logic [hpr_pkg::DEN_W:0]     shifted;
    logic [hpr_pkg::DEN_W+1:0]   diff;
    logic                        qbit;

    always_comb
    begin
        shifted = {rem_reg, dvd_reg[hpr_pkg::NUM_W-1]};
        diff    = {1'b0, shifted} - {2'b00, den_reg};
        qbit    = ~diff[hpr_pkg::DEN_W+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= hpr_pkg::CNT_W'(hpr_pkg::NUM_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? diff[hpr_pkg::DEN_W-1:0] : shifted[hpr_pkg::DEN_W-1:0];
            dvd_reg <= {dvd_reg[hpr_pkg::NUM_W-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ===== hw/rtl/heater_power_ramp_slow_pwm.sv =====
// heater power ramp from sampled temperature with a slow 1000-tick pwm
// depends on hpr_pkg and hpr_div
`timescale 1ns / 1ps
// order: a tick without a sample goes from idle straight to the pwm step; a sampled tick
// passes temp and cmp first, and in the ramp case also mul, divgo, the bit-serial divider and fin
// flow: one tick at a time; no new tick while one is in work; the pwm step waits for a free output slot
// reset: async active low, clears controls, counters and config but sample_interval; first tick samples

module heater_power_ramp_slow_pwm
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [hpr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hpr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,  // sensor_raw[11:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // heater_on[0], power_percent[7:1], temp_tenths[19:8]
    output logic [23:0]                      m_tdata,
    output logic                             m_tuser   // sampled
);

    hpr_pkg::state_t                      state_reg;
    hpr_pkg::cfg_t                        cfg_reg;
    logic [hpr_pkg::IVAL_W-1:0]           sample_wait_reg;
    logic [hpr_pkg::PHASE_W-1:0]          phase_wait_reg;
    logic                                 drive_reg;
    logic [hpr_pkg::HEAT_W-1:0]           power_reg;
    logic signed [hpr_pkg::TEMP_W-1:0]    temp_reg;
    logic                                 took_reg;
    logic [hpr_pkg::RAW_W-1:0]            raw_reg;
    logic signed [20:0]                   prod_reg;

    logic                                 m_tvalid_reg;
    logic                                 o_heater_reg;
    logic [hpr_pkg::HEAT_W-1:0]           o_power_reg;
    logic [hpr_pkg::TEMP_W-1:0]           o_temp_reg;
    logic                                 o_took_reg;

    logic [15:0]                          raw_ext;
    logic [15:0]                          x10;
    logic [15:0]                          x10_adj;
    logic [12:0]                          temp_calc;
    logic signed [12:0]                   t_diff;
    logic signed [7:0]                    heat_diff;
    logic signed [12:0]                   den_full;
    logic [hpr_pkg::NUM_W-1:0]            num_abs;
    logic signed [9:0]                    ramp_q;
    logic signed [9:0]                    ramp_p;
    logic [hpr_pkg::PHASE_W-1:0]          pstep;
    logic                                 slot_free;
    logic                                 div_start;
    logic                                 div_done;
    logic [hpr_pkg::NUM_W-1:0]            div_q;

    function automatic logic [hpr_pkg::HEAT_W-1:0] sat_heat(input logic [hpr_pkg::HEAT_W-1:0] h);
        sat_heat = (h > hpr_pkg::POWER_MAX) ? hpr_pkg::POWER_MAX : h;
    endfunction

    always_comb
    begin
        raw_ext   = {{4{raw_reg[hpr_pkg::RAW_W-1]}}, raw_reg};
        x10       = (raw_ext << 3) + (raw_ext << 1);
        x10_adj   = x10 + (x10[15] ? 16'd15 : 16'd0);
        temp_calc = {x10_adj[15], x10_adj[15:4]} - hpr_pkg::TEMP_OFFSET;

        t_diff    = 13'(temp_reg) - 13'(cfg_reg.start_temp);
        heat_diff = $signed({1'b0, cfg_reg.max_heat}) - $signed({1'b0, cfg_reg.start_heat});
        den_full  = 13'(cfg_reg.start_temp) - 13'(cfg_reg.limit_temp);
        num_abs   = prod_reg[20] ? hpr_pkg::NUM_W'(-prod_reg) : prod_reg[hpr_pkg::NUM_W-1:0];

        // the divider takes start minus limit, but the ramp divides by limit minus start, so the sign flips
        ramp_q    = prod_reg[20] ? $signed({2'b00, div_q[7:0]}) : -$signed({2'b00, div_q[7:0]});
        ramp_p    = ramp_q + $signed({3'b000, cfg_reg.start_heat});

        pstep     = (hpr_pkg::PHASE_W'(power_reg) << 3) + (hpr_pkg::PHASE_W'(power_reg) << 1);
        slot_free = !m_tvalid_reg || m_tready;
        div_start = (state_reg == hpr_pkg::ST_DIVGO);
    end

    hpr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_abs),
        .divisor  (den_full[hpr_pkg::DEN_W-1:0]),
        .done     (div_done),
        .quotient (div_q)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_temp      <= '0;
            cfg_reg.start_heat      <= '0;
            cfg_reg.limit_temp      <= '0;
            cfg_reg.max_heat        <= '0;
            cfg_reg.sample_interval <= hpr_pkg::SAMPLE_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                hpr_pkg::REG_START_TEMP:      cfg_reg.start_temp      <= cfg_data[11:0];
                hpr_pkg::REG_START_HEAT:      cfg_reg.start_heat      <= cfg_data[6:0];
                hpr_pkg::REG_LIMIT_TEMP:      cfg_reg.limit_temp      <= cfg_data[11:0];
                hpr_pkg::REG_MAX_HEAT:        cfg_reg.max_heat        <= cfg_data[6:0];
                hpr_pkg::REG_SAMPLE_INTERVAL: cfg_reg.sample_interval <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and tick state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= hpr_pkg::ST_IDLE;
            sample_wait_reg <= '0;
            phase_wait_reg  <= '0;
            drive_reg       <= 1'b0;
            power_reg       <= '0;
            temp_reg        <= '0;
            took_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (state_reg == hpr_pkg::ST_PWM && slot_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                hpr_pkg::ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        if (sample_wait_reg == '0)
                        begin
                            took_reg  <= 1'b1;
                            state_reg <= hpr_pkg::ST_TEMP;
                        end
                        else
                        begin
                            sample_wait_reg <= sample_wait_reg - 1'b1;
                            took_reg        <= 1'b0;
                            state_reg       <= hpr_pkg::ST_PWM;
                        end
                    end
                end
                hpr_pkg::ST_TEMP:
                begin
                    temp_reg        <= temp_calc[hpr_pkg::TEMP_W-1:0];
                    sample_wait_reg <= cfg_reg.sample_interval;
                    state_reg       <= hpr_pkg::ST_CMP;
                end
                hpr_pkg::ST_CMP:
                begin
                    if (temp_reg > cfg_reg.start_temp)
                    begin
                        power_reg <= '0;
                        state_reg <= hpr_pkg::ST_PWM;
                    end
                    else if (temp_reg < cfg_reg.limit_temp)
                    begin
                        power_reg <= sat_heat(cfg_reg.max_heat);
                        state_reg <= hpr_pkg::ST_PWM;
                    end
                    else if (cfg_reg.start_temp == cfg_reg.limit_temp)
                    begin
                        power_reg <= sat_heat(cfg_reg.start_heat);
                        state_reg <= hpr_pkg::ST_PWM;
                    end
                    else
                    begin
                        state_reg <= hpr_pkg::ST_MUL;
                    end
                end
                hpr_pkg::ST_MUL:
                begin
                    state_reg <= hpr_pkg::ST_DIVGO;
                end
                hpr_pkg::ST_DIVGO:
                begin
                    state_reg <= hpr_pkg::ST_DIV;
                end
                hpr_pkg::ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= hpr_pkg::ST_FIN;
                    end
                end
                hpr_pkg::ST_FIN:
                begin
                    if (ramp_p < 0)
                    begin
                        power_reg <= '0;
                    end
                    else if (ramp_p > $signed({3'b000, hpr_pkg::POWER_MAX}))
                    begin
                        power_reg <= hpr_pkg::POWER_MAX;
                    end
                    else
                    begin
                        power_reg <= ramp_p[hpr_pkg::HEAT_W-1:0];
                    end
                    state_reg <= hpr_pkg::ST_PWM;
                end
                hpr_pkg::ST_PWM:
                begin
                    if (slot_free)
                    begin
                        if (phase_wait_reg == '0)
                        begin
                            if (!drive_reg && power_reg != '0)
                            begin
                                drive_reg      <= 1'b1;
                                phase_wait_reg <= pstep;
                            end
                            else
                            begin
                                drive_reg      <= 1'b0;
                                phase_wait_reg <= hpr_pkg::PWM_PERIOD - pstep;
                            end
                        end
                        else
                        begin
                            phase_wait_reg <= phase_wait_reg - 1'b1;
                        end
                        state_reg <= hpr_pkg::ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= hpr_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            raw_reg <= s_tdata[hpr_pkg::RAW_W-1:0];
        end
        if (state_reg == hpr_pkg::ST_MUL)
        begin
            prod_reg <= t_diff * heat_diff;
        end
        if (state_reg == hpr_pkg::ST_PWM && slot_free)
        begin
            if (phase_wait_reg == '0)
            begin
                o_heater_reg <= !drive_reg && power_reg != '0;
            end
            else
            begin
                o_heater_reg <= drive_reg;
            end
            o_power_reg <= power_reg;
            o_temp_reg  <= temp_reg;
            o_took_reg  <= took_reg;
        end
    end

    assign s_tready = (state_reg == hpr_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, o_temp_reg, o_power_reg, o_heater_reg};
    assign m_tuser  = o_took_reg;

    a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:1] <= hpr_pkg::POWER_MAX))
        else $error("power above range on output");

    a_valid_from_pwm: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == hpr_pkg::ST_PWM))
        else $error("result appeared outside pwm step");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == hpr_pkg::ST_DIV))
        else $error("divider finished outside divide step");

    a_sample_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hpr_pkg::ST_TEMP) |=> (sample_wait_reg == cfg_reg.sample_interval))
        else $error("sample countdown not reloaded");

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for heater_power_ramp_slow_pwm: sensor ticks in, pwm state out
// tracks sampling, power ramp and slow pwm per tick and checks every result transfer
// depends on hpr_pkg and the heater_power_ramp_slow_pwm rtl
`timescale 1ns / 1ps

module tb;

    localparam int OFFSET_TENTHS = 150;
    localparam int PWM_TICKS     = 1000;
    localparam int PWM_STEP      = 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int TIMEOUT_NS    = 8_000_000;

    typedef struct {
        bit                                heater_on;
        logic [hpr_pkg::HEAT_W-1:0]        power;
        logic signed [hpr_pkg::TEMP_W-1:0] temp;
        bit                                sampled;
    } tick_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [hpr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [hpr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [15:0]                    s_tdata = '0;   // sensor_raw[11:0]
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    // heater_on[0], power_percent[7:1], temp_tenths[19:8]
    logic [23:0]                    m_tdata;
    logic                           m_tuser;        // sampled

    logic hold_req = 1'b0;
    logic rx_hold = 1'b0;
    int   tx_idle = 0;
    int   rx_idle = 0;
    int   mismatch_count = 0;

    tick_result_t expected_ticks[$];

    // tracked block state
    hpr_pkg::cfg_t                     cfg_now = '{12'sd0, 7'd0, 12'sd0, 7'd0,
                                                   hpr_pkg::SAMPLE_RESET};
    logic [hpr_pkg::IVAL_W-1:0]        smp_wait = '0;
    logic [hpr_pkg::PHASE_W-1:0]       phase_left = '0;
    bit                                heater_drive = 1'b0;
    logic [hpr_pkg::HEAT_W-1:0]        power_now = '0;
    logic signed [hpr_pkg::TEMP_W-1:0] temp_now = '0;

    heater_power_ramp_slow_pwm dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("heater_power_ramp_slow_pwm test failed");
        $finish;
    end

    function automatic logic [hpr_pkg::HEAT_W-1:0] ramp_power(int t);
        int st;
        int lt;
        int sh;
        int mh;
        int p;
        st = int'($signed(cfg_now.start_temp));
        lt = int'($signed(cfg_now.limit_temp));
        sh = int'(cfg_now.start_heat);
        mh = int'(cfg_now.max_heat);
        if (t > st)
            p = 0;
        else if (t < lt)
            p = mh;
        else if (st == lt)
            p = sh;
        else
            p = (t - st) * (mh - sh) / (lt - st) + sh;
        if (p < 0)
            p = 0;
        if (p > 100)
            p = 100;
        return hpr_pkg::HEAT_W'(p);
    endfunction

    // sample step first, pwm step second, as in the block
    function automatic tick_result_t predict_heater_tick(logic signed [hpr_pkg::RAW_W-1:0] raw);
        tick_result_t r;
        int t;
        r.sampled = 1'b0;
        if (smp_wait == '0)
        begin
            t = (int'(raw) * 10) / 16 - OFFSET_TENTHS;
            temp_now = hpr_pkg::TEMP_W'(t);
            power_now = ramp_power(t);
            smp_wait = cfg_now.sample_interval;
            r.sampled = 1'b1;
        end
        else
        begin
            smp_wait = smp_wait - 1'b1;
        end
        if (phase_left == '0)
        begin
            if (!heater_drive && power_now != '0)
            begin
                heater_drive = 1'b1;
                phase_left = hpr_pkg::PHASE_W'(int'(power_now) * PWM_STEP);
            end
            else
            begin
                heater_drive = 1'b0;
                phase_left = hpr_pkg::PHASE_W'(PWM_TICKS - int'(power_now) * PWM_STEP);
            end
        end
        else
        begin
            phase_left = phase_left - 1'b1;
        end
        r.heater_on = heater_drive;
        r.power = power_now;
        r.temp = temp_now;
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        tick_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_ticks.size() == 0)
            begin
                mismatch_count++;
                $display("%0t unexpected transfer: expected none actual %h/%b",
                         $time, m_tdata, m_tuser);
            end
            else
            begin
                want = expected_ticks.pop_front();
                check_field("heater_on", want.heater_on, m_tdata[0]);
                check_field("power_percent", want.power, m_tdata[7:1]);
                check_field("temp_tenths", int'(want.temp), int'($signed(m_tdata[19:8])));
                check_field("sampled", want.sampled, m_tuser);
            end
        end
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle);
    end

    // long receiver hold-off, counted here
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
        end
    end

    task automatic send_tick(logic signed [hpr_pkg::RAW_W-1:0] raw);
        while ($urandom_range(99) < tx_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0000, raw};
        do @(posedge clk); while (!s_tready);
        expected_ticks.push_back(predict_heater_tick(raw));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (expected_ticks.size() != 0);
    endtask

    task automatic write_reg(hpr_pkg::reg_index_t idx, logic [hpr_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic load_config(hpr_pkg::cfg_t c);
        drain_results();
        write_reg(hpr_pkg::REG_START_TEMP, {{4{c.start_temp[11]}}, c.start_temp});
        write_reg(hpr_pkg::REG_START_HEAT, {9'd0, c.start_heat});
        write_reg(hpr_pkg::REG_LIMIT_TEMP, {{4{c.limit_temp[11]}}, c.limit_temp});
        write_reg(hpr_pkg::REG_MAX_HEAT, {9'd0, c.max_heat});
        write_reg(hpr_pkg::REG_SAMPLE_INTERVAL, c.sample_interval);
        cfg_wr_en <= 1'b0;
        cfg_now = c;
        @(posedge clk);
    endtask

    function automatic logic signed [hpr_pkg::TEMP_W-1:0] rand_temp();
        case ($urandom_range(9))
            0: return -12'sd2048;
            1: return 12'sd2047;
            default: return hpr_pkg::TEMP_W'(int'($urandom_range(2559)) - 1430);
        endcase
    endfunction

    function automatic logic [hpr_pkg::HEAT_W-1:0] rand_heat();
        if ($urandom_range(7) == 0)
            return hpr_pkg::HEAT_W'($urandom_range(127, 101));
        return hpr_pkg::HEAT_W'($urandom_range(100));
    endfunction

    function automatic hpr_pkg::cfg_t rand_cfg(int max_ival);
        hpr_pkg::cfg_t c;
        int kind;
        int lim;
        c.start_temp = rand_temp();
        kind = $urandom_range(9);
        if (kind < 6)
        begin
            lim = int'($signed(c.start_temp)) - int'($urandom_range(600, 1));
            if (lim < -2048)
                lim = -2048;
            c.limit_temp = hpr_pkg::TEMP_W'(lim);
        end
        else if (kind == 6)
        begin
            c.limit_temp = c.start_temp;
        end
        else
        begin
            c.limit_temp = rand_temp();
        end
        c.start_heat = rand_heat();
        c.max_heat = rand_heat();
        c.sample_interval = hpr_pkg::IVAL_W'($urandom_range(max_ival));
        return c;
    endfunction

    // mostly readings around the ramp window, some anywhere
    function automatic logic signed [hpr_pkg::RAW_W-1:0] rand_raw();
        int st;
        int lt;
        int lo;
        int hi;
        int r;
        if ($urandom_range(9) < 3)
            return hpr_pkg::RAW_W'($urandom);
        st = int'($signed(cfg_now.start_temp));
        lt = int'($signed(cfg_now.limit_temp));
        lo = ((st < lt) ? st : lt) - 20;
        hi = ((st < lt) ? lt : st) + 20;
        r = (lo + int'($urandom_range(hi - lo)) + OFFSET_TENTHS) * 16 / 10;
        r = r + int'($urandom_range(1));
        if (r < -2048)
            r = -2048;
        if (r > 2047)
            r = 2047;
        return hpr_pkg::RAW_W'(r);
    endfunction

    // full power right after an on phase leaves an off phase of one tick
    task automatic test_full_power_gap();
        load_config('{12'sd1129, 7'd1, -12'sd1430, 7'd1, 16'd0});
        repeat (11) send_tick(hpr_pkg::RAW_W'($urandom));
        load_config('{12'sd1129, 7'd100, -12'sd1430, 7'd100, 16'd0});
        repeat (3) send_tick(hpr_pkg::RAW_W'($urandom));
    endtask

    task automatic test_ramp_regions();
        load_config('{12'sd100, 7'd10, -12'sd100, 7'd90, 16'd0});
        send_tick(12'sd2047);
        send_tick(-12'sd2048);
        send_tick(12'sd240);
        send_tick(12'sd400);
        send_tick(12'sd402);
        send_tick(12'sd80);
    endtask

    task automatic test_equal_temps();
        load_config('{-12'sd150, 7'd33, -12'sd150, 7'd77, 16'd0});
        send_tick(12'sd0);
        send_tick(-12'sd7);
        send_tick(12'sd16);
    endtask

    task automatic test_limit_above_start();
        load_config('{-12'sd500, 7'd127, 12'sd500, 7'd127, 16'd1});
        send_tick(-12'sd2048);
        send_tick(12'sd2047);
        send_tick(-12'sd560);
    endtask

    // falling ramp, quotient truncates toward zero
    task automatic test_truncation();
        load_config('{-12'sd100, 7'd100, -12'sd300, 7'd0, 16'd0});
        send_tick(-12'sd2);
        send_tick(-12'sd3);
    endtask

    task automatic test_random_ramps();
        repeat (8)
        begin
            load_config(rand_cfg(12));
            repeat (25) send_tick(rand_raw());
        end
    endtask

    task automatic test_backpressure();
        drain_results();
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        repeat (8) send_tick(rand_raw());
        drain_results();
    endtask

    task automatic test_long_interval();
        hpr_pkg::cfg_t c;
        c = rand_cfg(0);
        c.sample_interval = 16'hFFFF;
        load_config(c);
        repeat (15) send_tick(rand_raw());
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle = 30;
        rx_idle = 77;
        test_full_power_gap();
        test_ramp_regions();
        test_equal_temps();
        test_limit_above_start();
        test_truncation();
        test_random_ramps();
        test_backpressure();

        tx_idle = 77;
        rx_idle = 30;
        test_random_ramps();

        tx_idle = 0;
        rx_idle = 0;
        test_random_ramps();
        test_long_interval();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_ticks.size() == 0)
            $display("heater_power_ramp_slow_pwm test passed");
        else
            $display("heater_power_ramp_slow_pwm test failed");
        $finish;
    end

endmodule

// ===== heater_power_ramp_slow_pwm.f =====
hw/rtl/hpr_pkg.sv
hw/rtl/hpr_div.sv
hw/rtl/heater_power_ramp_slow_pwm.sv
tb/sv/tb.sv
